/* hw/rtl/wsfd_pkg.sv */
`timescale 1ns / 1ps

package wsfd_pkg;

    localparam int unsigned MAX_FRAME_BYTES = 4096;
    localparam int unsigned LEN_W           = 12;
    localparam logic [LEN_W-1:0] LEN_CAP    = LEN_W'(MAX_FRAME_BYTES - 1);
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 12'd4095;

    localparam logic [3:0] OPCODE_MASK  = 4'hF;
    localparam logic [3:0] OPCODE_CLOSE = 4'h8;
    localparam logic [6:0] LEN_CODE_16  = 7'd126;
    localparam logic [6:0] LEN_CODE_64  = 7'd127;
    localparam logic [3:0] EXT_BYTES_16 = 4'd2;
    localparam logic [3:0] EXT_BYTES_64 = 4'd8;

    localparam logic REG_MAX_LEN = 1'b0;

    typedef enum logic [2:0] {
        PH_HEAD0,
        PH_HEAD1,
        PH_HEAD1_CLOSE,
        PH_EXT,
        PH_DATA,
        PH_SKIP
    } t_phase;

    typedef enum logic [2:0] {
        ST_PAYLOAD  = 3'd0,
        ST_CLOSE    = 3'd1,
        ST_SHORT    = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_TRUNC    = 3'd4,
        ST_OVERSIZE = 3'd5
    } t_status;

endpackage

/* hw/rtl/websocket_frame_decoder_top.sv */
`timescale 1ns / 1ps

// WebSocket frame deframer: one received buffer enters as bytes, one word per
// cycle, with i_in_last on the buffer's final byte. The two-byte header plus
// 2 or 8 extended length bytes is parsed, then the payload bytes come out
// with o_out_last on the final one; trailing bytes up to the buffer end are
// dropped. A close opcode, a too short or truncated buffer, an empty payload
// and a length above max_payload_length (APB register at address 0) each give
// one word with a nonzero o_status and o_out_last set. The header/counter
// update sits between the state registers and a single output register, so
// one word is accepted per cycle while the output register is empty or being
// drained; each result word appears in the cycle after its byte is accepted.
module websocket_frame_decoder_top
    import wsfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_out_last,
    output logic [2:0]  o_status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_phase           r_phase, n_phase;
    logic [3:0]       r_ext_cnt, n_ext_cnt;
    logic [LEN_W-1:0] r_acc, n_acc;
    logic             r_big, n_big;
    logic [LEN_W-1:0] r_remain, n_remain;
    logic [LEN_W-1:0] r_max_len;

    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_last;
    t_status          r_out_status;

    logic             res_valid;
    logic [7:0]       res_byte;
    logic             res_last;
    t_status          res_status;

    logic             accept;
    logic [6:0]       len_code;
    logic [3:0]       ext_dec;
    logic [LEN_W-1:0] ext_acc;
    logic             ext_big;
    logic [LEN_W-1:0] ld_len;
    logic             ld_big;
    t_status          ld_status;
    logic [LEN_W-1:0] limit;

    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;

    // ---- configuration ----
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MAX_LEN) ? {20'd0, r_max_len} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_MAX_LEN) begin
            r_max_len <= pwdata[LEN_W-1:0];
        end
    end

    assign limit = (r_max_len > LEN_CAP) ? LEN_CAP : r_max_len;

    // ---- length handling shared by header byte 1 and extension bytes ----
    // Only 12 bits of length are kept; anything shifted past them is sticky in big.
    assign len_code = i_in_byte[6:0];
    assign ext_dec  = r_ext_cnt - 4'd1;
    assign ext_acc  = {r_acc[3:0], i_in_byte};
    assign ext_big  = r_big || (r_acc[LEN_W-1:4] != '0);
    assign ld_len   = (r_phase == PH_EXT) ? ext_acc : {5'd0, len_code};
    assign ld_big   = (r_phase == PH_EXT) ? ext_big : 1'b0;

    always_comb begin
        if (ld_big || ld_len > limit) begin
            ld_status = ST_OVERSIZE;
        end else if (ld_len == '0) begin
            ld_status = ST_EMPTY;
        end else if (i_in_last) begin
            ld_status = ST_TRUNC;
        end else begin
            ld_status = ST_PAYLOAD;    // length fine, payload follows
        end
    end

    // ---- next state ----
    always_comb begin
        n_phase   = r_phase;
        n_ext_cnt = r_ext_cnt;
        n_acc     = r_acc;
        n_big     = r_big;
        n_remain  = r_remain;
        case (r_phase)
            PH_HEAD0: begin
                if (i_in_last) begin
                    n_phase = PH_HEAD0;
                end else if ((i_in_byte[3:0] & OPCODE_MASK) == OPCODE_CLOSE) begin
                    n_phase = PH_HEAD1_CLOSE;
                end else begin
                    n_phase = PH_HEAD1;
                end
            end
            PH_HEAD1_CLOSE: begin
                n_phase = i_in_last ? PH_HEAD0 : PH_SKIP;
            end
            PH_HEAD1: begin
                if (len_code == LEN_CODE_16 || len_code == LEN_CODE_64) begin
                    n_ext_cnt = (len_code == LEN_CODE_16) ? EXT_BYTES_16 : EXT_BYTES_64;
                    n_acc     = '0;
                    n_big     = 1'b0;
                    n_phase   = i_in_last ? PH_HEAD0 : PH_EXT;
                end else if (ld_status == ST_PAYLOAD) begin
                    n_remain = ld_len;
                    n_phase  = PH_DATA;
                end else begin
                    n_phase = i_in_last ? PH_HEAD0 : PH_SKIP;
                end
            end
            PH_EXT: begin
                n_acc     = ext_acc;
                n_big     = ext_big;
                n_ext_cnt = ext_dec;
                if (ext_dec == 4'd0) begin
                    if (ld_status == ST_PAYLOAD) begin
                        n_remain = ld_len;
                        n_phase  = PH_DATA;
                    end else begin
                        n_phase = i_in_last ? PH_HEAD0 : PH_SKIP;
                    end
                end else if (i_in_last) begin
                    n_phase = PH_HEAD0;
                end
            end
            PH_DATA: begin
                if (r_remain == LEN_W'(1)) begin
                    n_remain = '0;
                    n_phase  = i_in_last ? PH_HEAD0 : PH_SKIP;
                end else if (i_in_last) begin
                    n_remain = '0;
                    n_phase  = PH_HEAD0;
                end else begin
                    n_remain = r_remain - LEN_W'(1);
                end
            end
            PH_SKIP: begin
                if (i_in_last) begin
                    n_phase = PH_HEAD0;
                end
            end
            default: begin
                n_phase = PH_HEAD0;
            end
        endcase
    end

    // ---- result word ----
    always_comb begin
        res_valid  = 1'b0;
        res_byte   = 8'd0;
        res_last   = 1'b1;
        res_status = ST_PAYLOAD;
        case (r_phase)
            PH_HEAD0: begin
                if (i_in_last) begin
                    res_valid  = 1'b1;
                    res_status = ST_SHORT;
                end
            end
            PH_HEAD1_CLOSE: begin
                res_valid  = 1'b1;
                res_status = ST_CLOSE;
            end
            PH_HEAD1: begin
                if (len_code == LEN_CODE_16 || len_code == LEN_CODE_64) begin
                    res_valid  = i_in_last;
                    res_status = ST_TRUNC;
                end else begin
                    res_valid  = (ld_status != ST_PAYLOAD);
                    res_status = ld_status;
                end
            end
            PH_EXT: begin
                if (ext_dec == 4'd0) begin
                    res_valid  = (ld_status != ST_PAYLOAD);
                    res_status = ld_status;
                end else begin
                    res_valid  = i_in_last;
                    res_status = ST_TRUNC;
                end
            end
            PH_DATA: begin
                res_valid = 1'b1;
                if (r_remain == LEN_W'(1)) begin
                    res_byte = i_in_byte;
                end else if (i_in_last) begin
                    res_status = ST_TRUNC;
                end else begin
                    res_byte = i_in_byte;
                    res_last = 1'b0;
                end
            end
            default: begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEAD0;
            r_ext_cnt <= 4'd0;
            r_acc     <= '0;
            r_big     <= 1'b0;
            r_remain  <= '0;
        end else if (accept) begin
            r_phase   <= n_phase;
            r_ext_cnt <= n_ext_cnt;
            r_acc     <= n_acc;
            r_big     <= n_big;
            r_remain  <= n_remain;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= res_valid;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && res_valid) begin
            r_out_byte   <= res_byte;
            r_out_last   <= res_last;
            r_out_status <= res_status;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_out_last = r_out_last;
    assign o_status   = r_out_status;

`ifndef SYNTHESIS
    a_status_word_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_PAYLOAD |-> o_out_last && o_out_byte == 8'd0)
        else $error("status word without last flag or with nonzero byte");

    a_data_has_remaining: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DATA |-> r_remain != '0)
        else $error("payload phase with zero bytes remaining");

    a_ext_has_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_EXT |-> r_ext_cnt != 4'd0)
        else $error("extension phase with zero count");

    a_last_returns_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in_last |=> r_phase == PH_HEAD0)
        else $error("buffer end did not return to first header byte");
`endif

endmodule
